// File: hdl/deq_pkg.sv
// deq_pkg: shared types, codes and sizing constants for the double-ended queue
// no dependencies; imported by every module of the block except deq_ram
package deq_pkg;

  localparam int DEPTH   = 16;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int OFS_W   = 4;
  localparam int COUNT_W = 5;
  localparam int CMP_W   = (FILL_W > OFS_W) ? FILL_W : OFS_W;
  localparam int SUM_W   = ((PTR_W > OFS_W) ? PTR_W : OFS_W) + 1;

  typedef enum logic [2:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_PEEK_FRONT = 3'd4,
    FN_PEEK_BACK  = 3'd5,
    FN_PEEK_AT    = 3'd6,
    FN_CLEAR      = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2,
    STS_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    func_t                    func;
    logic signed [WORD_W-1:0] value;
    logic [OFS_W-1:0]         offset;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    status_t                  status;
    logic [COUNT_W-1:0]       count;
  } rsp_t;

  // sequencer to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

// File: hdl/deq_ram.sv
// deq_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/deq_ctrl.sv
// deq_ctrl: request sequencer for the double-ended queue
// depends on deq_pkg
module deq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output deq_pkg::cmd_t cmd
);
  import deq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy     = (state != ST_IDLE);
  assign done     = (state == ST_DONE);
  assign cmd.load = accept;
  assign cmd.exec = (state == ST_EXEC);

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> cmd.exec) else $error("accepted request not executed");
  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> done) else $error("execute not followed by result");
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> (!busy && !done)) else $error("result strobe longer than one cycle");

endmodule

// File: hdl/deq_dp.sv
// deq_dp: ring pointers, fill count and slot ram of the double-ended queue
// depends on deq_pkg and deq_ram
module deq_dp (
  input  logic          clk,
  input  logic          rst,
  input  deq_pkg::cmd_t cmd,
  input  deq_pkg::req_t req,
  output deq_pkg::rsp_t rsp
);
  import deq_pkg::*;

  req_t              req_q;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [FILL_W-1:0] fill, fill_next;
  status_t           status_q, status_next;
  logic              rd_ok, rd_ok_next;

  logic              we;
  logic [PTR_W-1:0]  waddr, raddr;
  logic [WORD_W-1:0] rdata;

  logic [PTR_W-1:0]  head_inc, head_dec, tail_inc, tail_dec, at_addr;
  logic [SUM_W-1:0]  at_sum;
  logic              is_empty, is_full, ofs_out;

  assign is_empty = (fill == '0);
  assign is_full  = (fill == FILL_W'(DEPTH));
  assign ofs_out  = (CMP_W'(req_q.offset) >= CMP_W'(fill));

  assign head_inc = (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
  assign head_dec = (head == '0) ? PTR_W'(DEPTH - 1) : head - PTR_W'(1);
  assign tail_inc = (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + PTR_W'(1);
  assign tail_dec = (tail == '0) ? PTR_W'(DEPTH - 1) : tail - PTR_W'(1);

  // offset is below fill when used, so the sum stays under twice the depth
  assign at_sum  = SUM_W'(head) + SUM_W'(req_q.offset);
  assign at_addr = (at_sum >= SUM_W'(DEPTH)) ? PTR_W'(at_sum - SUM_W'(DEPTH))
                                             : PTR_W'(at_sum);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    fill_next   = fill;
    status_next = status_q;
    rd_ok_next  = rd_ok;
    we          = 1'b0;
    waddr       = head;
    raddr       = head;
    if (cmd.exec) begin
      status_next = STS_OK;
      rd_ok_next  = 1'b0;
      unique case (req_q.func) inside
        FN_PUSH_FRONT, FN_PUSH_BACK: begin
          if (is_full) begin
            status_next = STS_FULL;
          end else begin
            we        = 1'b1;
            fill_next = fill + FILL_W'(1);
            if (is_empty) begin
              head_next = '0;
              tail_next = '0;
              waddr     = '0;
            end else if (req_q.func == FN_PUSH_FRONT) begin
              head_next = head_dec;
              waddr     = head_dec;
            end else begin
              tail_next = tail_inc;
              waddr     = tail_inc;
            end
          end
        end
        FN_POP_FRONT: begin
          if (is_empty) begin
            status_next = STS_EMPTY;
          end else begin
            raddr      = head;
            rd_ok_next = 1'b1;
            head_next  = head_inc;
            fill_next  = fill - FILL_W'(1);
          end
        end
        FN_POP_BACK: begin
          if (is_empty) begin
            status_next = STS_EMPTY;
          end else begin
            raddr      = tail;
            rd_ok_next = 1'b1;
            tail_next  = tail_dec;
            fill_next  = fill - FILL_W'(1);
          end
        end
        FN_PEEK_FRONT: begin
          if (is_empty) begin
            status_next = STS_EMPTY;
          end else begin
            raddr      = head;
            rd_ok_next = 1'b1;
          end
        end
        FN_PEEK_BACK: begin
          if (is_empty) begin
            status_next = STS_EMPTY;
          end else begin
            raddr      = tail;
            rd_ok_next = 1'b1;
          end
        end
        FN_PEEK_AT: begin
          if (is_empty) begin
            status_next = STS_EMPTY;
          end else if (ofs_out) begin
            status_next = STS_RANGE;
          end else begin
            raddr      = at_addr;
            rd_ok_next = 1'b1;
          end
        end
        FN_CLEAR: begin
          // vacated slots are never read before being rewritten
          head_next = '0;
          tail_next = '0;
          fill_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    status_q <= status_next;
    rd_ok    <= rd_ok_next;
  end

  deq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (req_q.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rsp.data   = rd_ok ? rdata : '0;
  assign rsp.status = status_q;
  assign rsp.count  = COUNT_W'(fill);

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH)) else $error("fill beyond capacity");
  a_full_keep: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && is_full && (req_q.func == FN_PUSH_FRONT || req_q.func == FN_PUSH_BACK))
      |=> $stable(fill)) else $error("refused push changed fill");

endmodule

// File: hdl/double_ended_queue.sv
// double_ended_queue: top level of the fixed-capacity circular deque of 32-bit words
// depends on deq_pkg, deq_ctrl, deq_dp (and deq_ram through deq_dp)
//
//  channel   handshake        payload        direction
//  request   start / busy     req (req_t)    in: transfer when start && !busy
//  result    done (strobe)    rsp (rsp_t)    out: transfer on the cycle done is high
//
// each request passes through accept, ring update with one slot access, and the
// registered read of the slot ram; the sequencer in deq_ctrl sets these steps
// busy is high from the cycle after acceptance until done has been shown
// done is high for exactly one cycle; the receiver cannot stall the result
// rst is synchronous and empties the queue (pointers and fill cleared)
module double_ended_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  deq_pkg::req_t req,
  output logic          done,
  output deq_pkg::rsp_t rsp
);
  import deq_pkg::*;

  cmd_t cmd;

  // sequencer: idle, execute, result
  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // datapath: request latch, head/tail/fill, slot ram and result forming
  deq_dp u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

// File: tb/tb_double_ended_queue.sv
// tb_double_ended_queue: self-checking testbench for the circular double-ended queue
// depends on deq_pkg and double_ended_queue; a scoreboard class predicts every result
// directed corner requests first, then random fill, drain and browse stretches
module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int RAND_ITEMS = 627;   // random requests after the directed part
  localparam int BLOCK_LEN  = 40;    // requests per random stretch
  localparam int TAIL_WAIT  = 8;     // cycles to watch for stray results at the end

  // scoreboard: ring predictor plus the queue of results still owed by the block
  class deq_scoreboard;
    logic signed [WORD_W-1:0] ring [DEPTH];
    int   head, tail, fill;
    rsp_t pending_rsp [$];
    int   errors, requests, results;
    int   full_refusals, empty_flags, range_flags;

    function new();
      wipe();
      errors = 0;
      requests = 0;
      results = 0;
      full_refusals = 0;
      empty_flags = 0;
      range_flags = 0;
    endfunction

    function void wipe();
      foreach (ring[i]) ring[i] = '0;
      head = 0;
      tail = 0;
      fill = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    // apply one accepted request to the ring and queue the result it owes
    function void note_request(req_t r);
      rsp_t e;
      e.data   = '0;
      e.status = STS_OK;
      requests++;
      case (r.func)
        FN_PUSH_FRONT, FN_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            e.status = STS_FULL;
          end else begin
            if (fill == 0) begin
              head = 0;
              tail = 0;
              ring[0] = r.value;
            end else if (r.func == FN_PUSH_FRONT) begin
              head = (head + DEPTH - 1) % DEPTH;
              ring[head] = r.value;
            end else begin
              tail = (tail + 1) % DEPTH;
              ring[tail] = r.value;
            end
            fill++;
          end
        end
        FN_POP_FRONT: begin
          if (fill == 0) begin
            e.status = STS_EMPTY;
          end else begin
            e.data = ring[head];
            ring[head] = '0;
            head = (head + 1) % DEPTH;
            fill--;
          end
        end
        FN_POP_BACK: begin
          if (fill == 0) begin
            e.status = STS_EMPTY;
          end else begin
            e.data = ring[tail];
            ring[tail] = '0;
            tail = (tail + DEPTH - 1) % DEPTH;
            fill--;
          end
        end
        FN_PEEK_FRONT: begin
          if (fill == 0) e.status = STS_EMPTY;
          else e.data = ring[head];
        end
        FN_PEEK_BACK: begin
          if (fill == 0) e.status = STS_EMPTY;
          else e.data = ring[tail];
        end
        FN_PEEK_AT: begin
          if (fill == 0) e.status = STS_EMPTY;
          else if (int'(r.offset) >= fill) e.status = STS_RANGE;
          else e.data = ring[(head + int'(r.offset)) % DEPTH];
        end
        default: begin
          wipe();
        end
      endcase
      e.count = COUNT_W'(fill);
      case (e.status)
        STS_FULL:  full_refusals++;
        STS_EMPTY: empty_flags++;
        STS_RANGE: range_flags++;
        default: ;
      endcase
      pending_rsp.push_back(e);
    endfunction

    // compare one result transfer against the oldest owed result
    function void check_result(rsp_t got);
      rsp_t e;
      results++;
      if (pending_rsp.size() == 0) begin
        flag($sformatf("result with nothing outstanding: data %h status %0d count %0d",
                       got.data, got.status, got.count));
        return;
      end
      e = pending_rsp.pop_front();
      if (got.data !== e.data || got.status !== e.status || got.count !== e.count)
        flag($sformatf("result %0d: data %h/%h status %0d/%0d count %0d/%0d (exp/got)",
                       results, e.data, got.data, e.status, got.status,
                       e.count, got.count));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t req = '0;
  rsp_t rsp;

  deq_scoreboard sb;
  bit            idle_on;   // when clear, requests go back to back

  double_ended_queue dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always #5 clk = ~clk;

  // result side: done marks a one-cycle transfer that cannot be held off
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(rsp);
  end

  function automatic req_t mk(func_t f, logic [WORD_W-1:0] v, logic [OFS_W-1:0] o);
    req_t r;
    r.func   = f;
    r.value  = v;
    r.offset = o;
    return r;
  endfunction

  // present one request and hold it until the transfer happens
  // called at a rising edge; start stays high across back-to-back requests
  task automatic issue(input req_t r);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  // hold the sender off until every owed result has come back
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk);
  endtask

  // random request shaped by stretch kind: 0 fill up, 1 drain down, 2 browse
  function automatic req_t pick_request(int kind, int fill);
    req_t        r;
    int unsigned p, push_lim, pop_lim;
    r.value  = $urandom;
    r.offset = OFS_W'($urandom_range(0, 15));
    p = $urandom_range(0, 99);
    push_lim = (kind == 0) ? 75 : (kind == 1) ? 20 : 35;
    pop_lim  = (kind == 0) ? 88 : (kind == 1) ? 80 : 55;
    if (p < push_lim) begin
      r.func = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
      // extremes of the word now and then
      case ($urandom_range(0, 11))
        0: r.value = 32'h8000_0000;
        1: r.value = 32'h7fff_ffff;
        2: r.value = 32'hffff_ffff;
        3: r.value = '0;
        default: ;
      endcase
    end else if (p < pop_lim) begin
      r.func = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
    end else if (p < 98) begin
      case ($urandom_range(0, 3))
        0: r.func = FN_PEEK_FRONT;
        1: r.func = FN_PEEK_BACK;
        default: begin
          r.func = FN_PEEK_AT;
          // mostly an offset that lands inside the stored words
          if (fill > 0 && $urandom_range(0, 2) != 0)
            r.offset = OFS_W'($urandom_range(0, fill - 1));
        end
      endcase
    end else begin
      r.func = FN_CLEAR;
    end
    return r;
  endfunction

  initial begin
    int sent;
    int blk;
    int kind;
    sb = new();
    idle_on = 1'b1;

    // synchronous reset, released before the directed requests
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty flags, word extremes, both ends, peek offsets in and out of range
    issue(mk(FN_POP_FRONT, '0, '0));
    issue(mk(FN_POP_BACK, '0, '0));
    issue(mk(FN_PEEK_FRONT, '0, '0));
    issue(mk(FN_PEEK_BACK, '0, '0));
    issue(mk(FN_PEEK_AT, '0, 4'd15));
    issue(mk(FN_PUSH_BACK, 32'h7fff_ffff, '0));
    issue(mk(FN_PUSH_FRONT, 32'h8000_0000, '0));
    issue(mk(FN_PUSH_BACK, 32'hffff_ffff, '0));
    issue(mk(FN_PUSH_FRONT, '0, 4'd15));
    issue(mk(FN_PEEK_FRONT, '0, '0));
    issue(mk(FN_PEEK_BACK, '0, '0));
    issue(mk(FN_PEEK_AT, '0, 4'd0));
    issue(mk(FN_PEEK_AT, '0, 4'd3));
    issue(mk(FN_PEEK_AT, '0, 4'd4));      // offset equal to fill
    issue(mk(FN_PEEK_AT, '0, 4'd15));
    issue(mk(FN_POP_FRONT, '0, '0));
    issue(mk(FN_POP_BACK, '0, '0));
    issue(mk(FN_POP_BACK, '0, '0));
    issue(mk(FN_POP_FRONT, '0, '0));      // queue empties with the tail pointer off zero
    issue(mk(FN_PUSH_FRONT, 32'h5a5a_5a5a, '0));  // push into empty restarts at slot 0
    issue(mk(FN_PUSH_BACK, 32'ha5a5_a5a5, '0));
    issue(mk(FN_CLEAR, 32'hffff_ffff, 4'd15));
    issue(mk(FN_PEEK_BACK, '0, '0));

    // random: stretches that fill, drain or browse, some with no idle cycles
    sent = 0;
    blk  = 0;
    while (sent < RAND_ITEMS) begin
      kind    = (blk < 2) ? 0 : $urandom_range(0, 2);   // reach full early on
      idle_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < BLOCK_LEN && sent < RAND_ITEMS; k++) begin
        issue(pick_request(kind, sb.fill));
        sent++;
      end
      // at least one full drain with the sender held off
      if (blk == 3 || $urandom_range(0, 4) == 0) drain();
      blk++;
    end

    // wait out the owed results, then watch for strays
    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.pending_rsp.size() != 0) sb.flag("results still owed at the end");

    $display("covered %0d requests and %0d results: %0d full refusals, %0d empty flags,",
             sb.requests, sb.results, sb.full_refusals, sb.empty_flags);
    $display("%0d offset range flags", sb.range_flags);
    if (sb.errors == 0) begin
      $display("tb_double_ended_queue OK");
    end else begin
      $display("%0d mismatches in total", sb.errors);
      $display("tb_double_ended_queue NOT OK");
    end
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin
    #3000000;
    $display("timeout waiting on the block");
    $display("tb_double_ended_queue NOT OK");
    $finish;
  end

endmodule
